@@ rtl/gsgl_pkg.sv @@
package gsgl_pkg;

    // Input word codes
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CALC  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE_X = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE_Z = 2'd2;

    localparam logic [23:0] SCALE_ONE  = 24'd65536;
    localparam int          SUM_W      = 39;   // exact stencil sum width
    localparam logic [3:0]  LAST_READ  = 4'd12;
    localparam logic [3:0]  LAST_MUL   = 4'd11;
    localparam logic [1:0]  LAST_RND   = 2'd3;

    typedef enum logic [2:0] {
        TAP_C, TAP_M1, TAP_M2, TAP_P1, TAP_P2
    } t_tap;

    typedef enum logic [2:0] {
        BS_CLEAR, BS_IDLE, BS_READ, BS_MUL, BS_ROUND, BS_OUT
    } t_bstate;

    // One queued word, coordinates already reduced to the grid
    typedef struct packed {
        logic               kind;
        logic [4:0]         x;
        logic [4:0]         y;
        logic [4:0]         z;
        logic signed [31:0] sample;
    } t_job;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } t_scales;

    typedef struct packed {
        logic [1:0] ax;
        t_tap       tap;
    } t_step;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_rnd;

    // Read order: center, then m1, m2, p1, p2 for x, y, z
    function automatic t_step f_step(input logic [3:0] k);
        t_step      s;
        logic [3:0] j;
        j     = k - 4'd1;
        s.ax  = j[3:2];
        s.tap = TAP_C;
        if (k != 4'd0) begin
            case (j[1:0])
                2'd0:    s.tap = TAP_M1;
                2'd1:    s.tap = TAP_M2;
                2'd2:    s.tap = TAP_P1;
                2'd3:    s.tap = TAP_P2;
                default: s.tap = TAP_C;
            endcase
        end
        return s;
    endfunction

    // Periodic neighbor coordinate, c below n
    function automatic logic [7:0] f_wrap(input logic [4:0] c, input t_tap tap,
                                          input logic [8:0] n);
        logic [9:0] s;
        case (tap)
            TAP_M1:  s = 10'(c) + 10'(n) - 10'd1;
            TAP_M2:  s = 10'(c) + 10'(n) - 10'd2;
            TAP_P1:  s = 10'(c) + 10'd1;
            TAP_P2:  s = 10'(c) + 10'd2;
            default: s = 10'(c);
        endcase
        if (s >= 10'(n)) begin
            s = s - 10'(n);
        end
        return s[7:0];
    endfunction

    // Round half up to Q16.16 and clip to 32 bits
    function automatic t_rnd f_round(input logic signed [63:0] p);
        t_rnd               r;
        logic signed [63:0] s;
        logic signed [47:0] q;
        s = p + 64'sd32768;
        q = 48'(s >>> 16);
        r.clip = 1'b0;
        r.val  = q[31:0];
        if (q > 48'sd2147483647) begin
            r.val  = 32'sh7fffffff;
            r.clip = 1'b1;
        end else if (q < -48'sd2147483648) begin
            r.val  = 32'sh80000000;
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ rtl/gsgl_queue.sv @@
module gsgl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gsgl_pkg::t_job i_data,
    input  logic          i_pop,
    output gsgl_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import gsgl_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/gsgl_front.sv @@
module gsgl_front #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [4:0]         i_x_index,
    input  logic [4:0]         i_y_index,
    input  logic [4:0]         i_z_index,
    input  logic signed [31:0] i_sample,
    input  logic               i_clearing,
    input  logic               i_full,
    output logic               o_push,
    output gsgl_pkg::t_job     o_job
);
    import gsgl_pkg::*;

    // Reduce a coordinate modulo a grid size of five or more
    function automatic logic [4:0] f_reduce(input logic [4:0] v, input int n);
        logic [4:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (n < 32 && 32'(r) >= n) begin
                r = r - 5'(n);
            end
        end
        return r;
    endfunction

    // Hold the channel while the grid clears or the queue is full
    assign o_in_stall = i_clearing | i_full;
    assign o_push     = i_in_valid & ~o_in_stall;

    // Classify and normalize the word
    always_comb begin
        o_job.kind   = i_kind;
        o_job.x      = f_reduce(i_x_index, GRID_X);
        o_job.y      = f_reduce(i_y_index, GRID_Y);
        o_job.z      = f_reduce(i_z_index, GRID_Z);
        o_job.sample = i_sample;
    end

endmodule

@@ rtl/gsgl_back.sv @@
module gsgl_back #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gsgl_pkg::t_job     i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_clearing,
    input  gsgl_pkg::t_scales  i_scales,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_grad_x,
    output logic signed [31:0] o_grad_y,
    output logic signed [31:0] o_grad_z,
    output logic signed [31:0] o_laplacian,
    output logic signed [31:0] o_center_value,
    output logic               o_saturated
);
    import gsgl_pkg::*;

    localparam int         DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int         AW    = $clog2(DEPTH);
    localparam logic [8:0] NX    = 9'(GRID_X);
    localparam logic [8:0] NY    = 9'(GRID_Y);
    localparam logic [8:0] NZ    = 9'(GRID_Z);

    logic [31:0] r_grid [DEPTH];

    t_bstate r_state, n_state;
    logic [AW-1:0] r_clr;
    t_job          r_job;
    logic [3:0]    r_step;
    logic          r_cap_vld;
    logic [3:0]    r_cap_step;
    logic [31:0]   r_rdata;
    logic signed [31:0]      r_f0;
    logic signed [SUM_W-1:0] r_gacc [3];
    logic signed [SUM_W-1:0] r_lacc [3];
    logic [3:0]    r_m;
    logic signed [45:0] r_prod;
    logic          r_pvld;
    logic [3:0]    r_pm;
    logic signed [63:0] r_gp [3];
    logic signed [63:0] r_lp;
    logic [1:0]    r_rnd;
    logic signed [31:0] r_res [4];
    logic          r_sat;
    logic          r_out_vld;
    logic signed [31:0] r_out_gx, r_out_gy, r_out_gz, r_out_lap, r_out_c;
    logic          r_out_sat;

    logic          w_mem_we, w_mem_re, w_load, w_start;
    t_job          w_src;
    t_step         w_st;
    logic [7:0]    w_xx, w_yy, w_zz;
    logic [AW-1:0] w_row, w_addr;
    logic [AW-1:0] w_maddr;
    t_step         w_cst;
    logic signed [SUM_W-1:0] w_d, w_d30;
    logic [1:0]    w_max;
    logic signed [SUM_W-1:0] w_msum;
    logic signed [20:0] w_ma;
    logic [23:0]   w_msc;
    logic signed [63:0] w_term;
    t_rnd          w_rv;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = BS_IDLE;
            BS_IDLE:  if (!i_empty && i_job.kind == KIND_CALC) n_state = BS_READ;
            BS_READ:  if (r_step == LAST_READ) n_state = BS_MUL;
            BS_MUL:   if (r_m == LAST_MUL) n_state = BS_ROUND;
            BS_ROUND: if (r_rnd == LAST_RND) n_state = BS_OUT;
            BS_OUT:   if (!r_out_vld || !i_out_stall) n_state = BS_IDLE;
            default:  n_state = BS_CLEAR;
        endcase
    end

    // Control strobes
    always_comb begin
        o_pop      = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_load     = 1'b0;
        w_start    = 1'b0;
        o_clearing = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                o_clearing = 1'b1;
                w_mem_we   = 1'b1;
            end
            BS_IDLE: begin
                o_pop    = !i_empty;
                w_mem_we = !i_empty && i_job.kind == KIND_WRITE;
                w_start  = !i_empty && i_job.kind == KIND_CALC;
            end
            BS_READ: w_mem_re = 1'b1;
            BS_OUT:  w_load   = !r_out_vld || !i_out_stall;
            default: o_pop    = 1'b0;
        endcase
    end

    // Stencil address for the current read
    always_comb begin
        w_src = (r_state == BS_READ) ? r_job : i_job;
        w_st  = (r_state == BS_READ) ? f_step(r_step) : '{ax: 2'd0, tap: TAP_C};
        w_xx  = f_wrap(w_src.x, (w_st.ax == 2'd0) ? w_st.tap : TAP_C, NX);
        w_yy  = f_wrap(w_src.y, (w_st.ax == 2'd1) ? w_st.tap : TAP_C, NY);
        w_zz  = f_wrap(w_src.z, (w_st.ax == 2'd2) ? w_st.tap : TAP_C, NZ);
        w_row  = AW'(AW'(w_xx) * AW'(GRID_Y) + AW'(w_yy));
        w_addr = AW'(w_row * AW'(GRID_Z) + AW'(w_zz));
        w_maddr = (r_state == BS_CLEAR) ? r_clr : w_addr;
    end

    // Grid memory, single port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_grid[w_maddr] <= (r_state == BS_CLEAR) ? 32'd0 : i_job.sample;
        end
        if (w_mem_re) begin
            r_rdata <= r_grid[w_maddr];
        end
    end

    // Fold each returned sample into the axis sums
    always_comb begin
        w_cst = f_step(r_cap_step);
        w_d   = SUM_W'($signed(r_rdata));
        w_d30 = (w_d <<< 5) - (w_d <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            if (w_cst.tap == TAP_C) begin
                r_f0 <= $signed(r_rdata);
                for (int a = 0; a < 3; a++) begin
                    r_gacc[a] <= '0;
                    r_lacc[a] <= -w_d30;
                end
            end else begin
                case (w_cst.tap)
                    TAP_M1: begin
                        r_gacc[w_cst.ax] <= r_gacc[w_cst.ax] - (w_d <<< 3);
                        r_lacc[w_cst.ax] <= r_lacc[w_cst.ax] + (w_d <<< 4);
                    end
                    TAP_M2: begin
                        r_gacc[w_cst.ax] <= r_gacc[w_cst.ax] + w_d;
                        r_lacc[w_cst.ax] <= r_lacc[w_cst.ax] - w_d;
                    end
                    TAP_P1: begin
                        r_gacc[w_cst.ax] <= r_gacc[w_cst.ax] + (w_d <<< 3);
                        r_lacc[w_cst.ax] <= r_lacc[w_cst.ax] + (w_d <<< 4);
                    end
                    TAP_P2: begin
                        r_gacc[w_cst.ax] <= r_gacc[w_cst.ax] - w_d;
                        r_lacc[w_cst.ax] <= r_lacc[w_cst.ax] - w_d;
                    end
                    default: r_f0 <= r_f0;
                endcase
            end
        end
    end

    // Multiplier operands: low 20 bits, then signed high part, per term
    always_comb begin
        w_max  = r_m[3:2];
        w_msum = r_m[1] ? r_lacc[w_max] : r_gacc[w_max];
        w_ma   = r_m[0] ? 21'($signed(w_msum[SUM_W-1:20])) : $signed({1'b0, w_msum[19:0]});
        case (w_max)
            2'd0:    w_msc = i_scales.x;
            2'd1:    w_msc = i_scales.y;
            default: w_msc = i_scales.z;
        endcase
        w_term = r_pm[0] ? (64'(r_prod) <<< 20) : 64'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * $signed({1'b0, w_msc});
        r_pm   <= r_m;
    end

    // Round one result a cycle
    assign w_rv = f_round((r_rnd == LAST_RND) ? r_lp : r_gp[r_rnd]);

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_job <= i_job;
            for (int a = 0; a < 3; a++) r_gp[a] <= '0;
            r_lp  <= '0;
            r_sat <= 1'b0;
        end else begin
            if (r_pvld) begin
                if (r_pm[1]) r_lp <= r_lp + w_term;
                else         r_gp[r_pm[3:2]] <= r_gp[r_pm[3:2]] + w_term;
            end
            if (r_state == BS_ROUND) begin
                r_res[r_rnd] <= w_rv.val;
                r_sat        <= r_sat | w_rv.clip;
            end
        end
    end

    // Sequence counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr     <= '0;
            r_step    <= '0;
            r_cap_vld <= 1'b0;
            r_cap_step <= '0;
            r_m       <= '0;
            r_pvld    <= 1'b0;
            r_rnd     <= '0;
        end else begin
            r_state    <= n_state;
            r_cap_vld  <= (r_state == BS_READ);
            r_cap_step <= r_step;
            r_pvld     <= (r_state == BS_MUL);
            if (r_state == BS_CLEAR) r_clr <= r_clr + 1'b1;
            r_step <= (r_state == BS_READ) ? r_step + 4'd1 : 4'd0;
            r_m    <= (r_state == BS_MUL) ? r_m + 4'd1 : 4'd0;
            r_rnd  <= (r_state == BS_ROUND) ? r_rnd + 2'd1 : 2'd0;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_gx  <= r_res[0];
            r_out_gy  <= r_res[1];
            r_out_gz  <= r_res[2];
            r_out_lap <= r_res[3];
            r_out_c   <= r_f0;
            r_out_sat <= r_sat;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_grad_x       = r_out_gx;
    assign o_grad_y       = r_out_gy;
    assign o_grad_z       = r_out_gz;
    assign o_laplacian    = r_out_lap;
    assign o_center_value = r_out_c;
    assign o_saturated    = r_out_sat;

    // No queue pop while the grid clears
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> !o_pop)
        else $error("pop during clear");

    // No grid write while a stencil is read
    a_no_write_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_READ) |-> !w_mem_we)
        else $error("write during stencil read");

    // Captured step stays within the stencil
    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_vld |-> (r_cap_step <= LAST_READ))
        else $error("capture step out of range");

    // A loaded word is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !w_load)
        else $error("result overwritten");

endmodule

@@ rtl/grid_stencil_gradient_laplacian_unit.sv @@
// Fourth-order stencil unit over a periodic 3D grid of Q16.16 samples.
// Input channel (i_in_valid / o_in_stall): a word with i_kind = 0 stores
// i_sample at the named point and gives no result; i_kind = 1 computes the
// three scaled gradients, the Laplacian and the center sample at the point.
// Output channel (o_out_valid / i_out_stall): one result word per compute.
// Configuration: i_cfg_we writes scale_x, scale_y or scale_z (index 0..2)
// from the low 24 bits of i_cfg_data; write only while the unit is idle.
// A two-word queue parts input decode from the sequencer, so the input keeps
// taking words while a result waits on a stalled receiver.
// A write word is stored from the sequencer's idle state. A compute word takes
// the pop, 13 reads from the single-port grid memory, 12 steps of
// the shared 21x25 multiplier, 4 rounding steps and the output load. At reset
// the scales return to 1.0 and the grid is swept to zero, one entry a cycle;
// input is stalled during the sweep.
// A stalled output word holds; the sequencer waits until it is taken.
module grid_stencil_gradient_laplacian_unit #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [4:0]         i_x_index,
    input  logic [4:0]         i_y_index,
    input  logic [4:0]         i_z_index,
    input  logic signed [31:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_grad_x,
    output logic signed [31:0] o_grad_y,
    output logic signed [31:0] o_grad_z,
    output logic signed [31:0] o_laplacian,
    output logic signed [31:0] o_center_value,
    output logic               o_saturated
);
    import gsgl_pkg::*;

    t_scales r_scales;
    t_job    w_push_job, w_head;
    logic    w_push, w_pop, w_full, w_empty, w_clearing;

    // Scale registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scales.x <= SCALE_ONE;
            r_scales.y <= SCALE_ONE;
            r_scales.z <= SCALE_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_X: r_scales.x <= i_cfg_data;
                CFG_SCALE_Y: r_scales.y <= i_cfg_data;
                CFG_SCALE_Z: r_scales.z <= i_cfg_data;
                default:     r_scales   <= r_scales;
            endcase
        end
    end

    gsgl_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_x_index  (i_x_index),
        .i_y_index  (i_y_index),
        .i_z_index  (i_z_index),
        .i_sample   (i_sample),
        .i_clearing (w_clearing),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    gsgl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    gsgl_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_clearing     (w_clearing),
        .i_scales       (r_scales),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_grad_z       (o_grad_z),
        .o_laplacian    (o_laplacian),
        .o_center_value (o_center_value),
        .o_saturated    (o_saturated)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import gsgl_pkg::*;

    localparam int GRID_N     = 32;
    localparam int CELLS      = GRID_N * GRID_N * GRID_N;
    localparam int WDOG_LIMIT = 200000;
    localparam int TAIL_START = 1000;

    typedef struct {
        logic               kind;
        logic [4:0]         x;
        logic [4:0]         y;
        logic [4:0]         z;
        logic signed [31:0] sample;
    } t_word;

    typedef struct {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic signed [31:0] lap;
        logic signed [31:0] ctr;
        logic               sat;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [4:0]         i_x_index;
    logic [4:0]         i_y_index;
    logic [4:0]         i_z_index;
    logic signed [31:0] i_sample;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_grad_x;
    logic signed [31:0] o_grad_y;
    logic signed [31:0] o_grad_z;
    logic signed [31:0] o_laplacian;
    logic signed [31:0] o_center_value;
    logic               o_saturated;

    // Shadow grid and scales
    logic signed [31:0] grid_mirror [CELLS];
    logic [23:0]        scale_mirror [3];

    t_word   pending_words [$];
    t_result stencil_expect [$];
    int      words_sent;
    int      drive_mark;
    int      mismatch_count;
    bit      timed_out;
    bit      quiet_mode;
    int      send_gap;
    int      recv_gap;
    int      idle_cycles;

    grid_stencil_gradient_laplacian_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int cell_index(int x, int y, int z);
        return ((x % GRID_N) * GRID_N + (y % GRID_N)) * GRID_N + (z % GRID_N);
    endfunction

    function automatic logic signed [63:0] sample_at(int x, int y, int z);
        return 64'(grid_mirror[cell_index(x, y, z)]);
    endfunction

    function automatic logic signed [31:0] round_clip(input logic signed [63:0] p,
                                                      inout logic clip);
        logic signed [63:0] q;
        q = (p + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // Apply one word to the shadow grid; return 1 with a result on compute
    function automatic bit predict_stencil(input t_word w, output t_result r);
        int                 c [3];
        int                 p [3];
        logic signed [63:0] f0, fm1, fm2, fp1, fp2, g, l, lap_sum;
        logic signed [31:0] gv [3];
        logic               clip;
        c[0] = w.x; c[1] = w.y; c[2] = w.z;
        r = '{default: '0};
        if (w.kind == KIND_WRITE) begin
            grid_mirror[cell_index(c[0], c[1], c[2])] = w.sample;
            return 1'b0;
        end
        clip = 1'b0;
        lap_sum = 0;
        f0 = sample_at(c[0], c[1], c[2]);
        for (int a = 0; a < 3; a++) begin
            p = c;
            p[a] = (c[a] + GRID_N - 1) % GRID_N; fm1 = sample_at(p[0], p[1], p[2]);
            p[a] = (c[a] + GRID_N - 2) % GRID_N; fm2 = sample_at(p[0], p[1], p[2]);
            p[a] = (c[a] + 1) % GRID_N;          fp1 = sample_at(p[0], p[1], p[2]);
            p[a] = (c[a] + 2) % GRID_N;          fp2 = sample_at(p[0], p[1], p[2]);
            g = 8 * (fp1 - fm1) + fm2 - fp2;
            l = 16 * (fm1 + fp1) - fm2 - fp2 - 30 * f0;
            gv[a] = round_clip(g * $signed({40'd0, scale_mirror[a]}), clip);
            lap_sum += l * $signed({40'd0, scale_mirror[a]});
        end
        r.gx  = gv[0];
        r.gy  = gv[1];
        r.gz  = gv[2];
        r.lap = round_clip(lap_sum, clip);
        r.ctr = f0[31:0];
        r.sat = clip;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return $signed(32'($urandom_range(0, 255)) - 32'd128) <<< 16;
            3:       return $signed(32'($urandom_range(0, 2047)) - 32'd1024);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic add_word(input logic k, input int x, input int y, input int z,
                            input logic signed [31:0] s);
        t_word w;
        w.kind = k; w.x = 5'(x); w.y = 5'(y); w.z = 5'(z); w.sample = s;
        pending_words.push_back(w);
    endtask

    // Fill a neighborhood of a random point then compute at it, or send one random word
    task automatic add_random_phase(input int count);
        int cx, cy, cz;
        for (int i = 0; i < count; i++) begin
            cx = $urandom_range(0, 31); cy = $urandom_range(0, 31); cz = $urandom_range(0, 31);
            if ($urandom_range(0, 9) < 8) begin
                for (int j = 0; j < $urandom_range(3, 10); j++) begin
                    case ($urandom_range(0, 2))
                        0: add_word(KIND_WRITE, (cx + $urandom_range(0, 4) + 30) % 32,
                                    cy, cz, pick_value());
                        1: add_word(KIND_WRITE, cx, (cy + $urandom_range(0, 4) + 30) % 32,
                                    cz, pick_value());
                        default: add_word(KIND_WRITE, cx, cy,
                                          (cz + $urandom_range(0, 4) + 30) % 32, pick_value());
                    endcase
                    i++;
                end
                add_word(KIND_CALC, cx, cy, cz, $signed($urandom()));
            end else begin
                add_word(1'($urandom_range(0, 1)), cx, cy, cz, $signed($urandom()));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || stencil_expect.size() != 0) begin
            @(posedge i_clk);
            if (timed_out) return;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        scale_mirror[idx] = val;
    endtask

    task automatic set_scales(input logic [23:0] sx, input logic [23:0] sy,
                              input logic [23:0] sz);
        write_scale(CFG_SCALE_X, sx);
        write_scale(CFG_SCALE_Y, sy);
        write_scale(CFG_SCALE_Z, sz);
    endtask

    // Stimulus and configuration phases
    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = CFG_SCALE_X; i_cfg_data = '0;
        i_in_valid = 1'b0; i_kind = KIND_WRITE; i_x_index = '0; i_y_index = '0;
        i_z_index = '0; i_sample = '0; i_out_stall = 1'b0;
        words_sent = 0; drive_mark = 0; mismatch_count = 0; timed_out = 1'b0;
        quiet_mode = 1'b0;
        send_gap = 0; recv_gap = 0; idle_cycles = 0;
        foreach (grid_mirror[i]) grid_mirror[i] = '0;
        foreach (scale_mirror[i]) scale_mirror[i] = SCALE_ONE;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero grid, extremes, wrap at the edges
        add_word(KIND_CALC, 0, 0, 0, 32'sh7fffffff);
        add_word(KIND_WRITE, 31, 31, 31, 32'sh7fffffff);
        add_word(KIND_WRITE, 1, 31, 31, 32'sh80000000);
        add_word(KIND_WRITE, 29, 31, 31, 32'sh7fffffff);
        add_word(KIND_WRITE, 31, 0, 31, 32'sh80000000);
        add_word(KIND_WRITE, 31, 30, 31, 32'sh00010000);
        add_word(KIND_WRITE, 31, 31, 0, 32'sh7fffffff);
        add_word(KIND_WRITE, 31, 31, 1, 32'sh80000000);
        add_word(KIND_CALC, 31, 31, 31, 32'sh0);
        add_word(KIND_CALC, 0, 31, 31, 32'sh0);
        add_word(KIND_CALC, 31, 0, 0, 32'sh0);
        add_word(KIND_WRITE, 0, 0, 0, -32'sh00018000);
        add_word(KIND_WRITE, 1, 0, 0, 32'sh00008000);
        add_word(KIND_CALC, 0, 0, 0, 32'sh0);
        add_word(KIND_CALC, 1, 0, 0, 32'sh0);
        add_word(KIND_CALC, 2, 0, 0, 32'sh0);
        wait_drained();

        set_scales(24'hffffff, 24'd0, 24'd1);
        add_word(KIND_CALC, 31, 31, 31, 32'sh0);
        add_word(KIND_CALC, 0, 0, 0, 32'sh0);
        add_random_phase(250);
        wait_drained();

        set_scales(24'd1, 24'hffffff, 24'd0);
        add_random_phase(250);
        wait_drained();

        set_scales(24'($urandom()), 24'($urandom()), 24'($urandom()));
        add_random_phase(250);
        wait_drained();

        set_scales(SCALE_ONE, 24'h008000, 24'h020000);
        add_random_phase(350);
        wait_drained();

        if (timed_out) begin
            $display("tb_top: FAIL");
        end else if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Drive input words at the falling edge; hold a word until it is taken
    always @(negedge i_clk) begin
        quiet_mode <= (words_sent >= TAIL_START) && (pending_words.size() < 150);
        if (i_rst_n) begin
            if (!i_in_valid || words_sent != drive_mark) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0 &&
                             (quiet_mode || $urandom_range(0, 9) != 0)) begin
                    i_in_valid <= 1'b1;
                    i_kind     <= pending_words[0].kind;
                    i_x_index  <= pending_words[0].x;
                    i_y_index  <= pending_words[0].y;
                    i_z_index  <= pending_words[0].z;
                    i_sample   <= pending_words[0].sample;
                    drive_mark <= words_sent;
                end else begin
                    i_in_valid <= 1'b0;
                    if (!quiet_mode && pending_words.size() != 0)
                        send_gap <= $urandom_range(0, 12);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Accept input words, check result words, watch for a hang
    always @(posedge i_clk) begin
        t_word   w;
        t_result r;
        t_result e;
        bit      busy;
        busy = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall && pending_words.size() != 0) begin
            w = pending_words.pop_front();
            if (predict_stencil(w, r)) stencil_expect.push_back(r);
            words_sent <= words_sent + 1;
            busy = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            busy = 1'b1;
            if (stencil_expect.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected result word");
            end else begin
                e = stencil_expect.pop_front();
                if (o_grad_x !== e.gx || o_grad_y !== e.gy || o_grad_z !== e.gz ||
                    o_laplacian !== e.lap || o_center_value !== e.ctr ||
                    o_saturated !== e.sat) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: exp %h %h %h %h %h %b got %h %h %h %h %h %b",
                                 e.gx, e.gy, e.gz, e.lap, e.ctr, e.sat, o_grad_x,
                                 o_grad_y, o_grad_z, o_laplacian, o_center_value,
                                 o_saturated);
                end
            end
        end
        // Idle drain pauses are short; the reset sweep is counted in the limit
        if (busy || (pending_words.size() == 0 && stencil_expect.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_LIMIT) begin
            timed_out <= 1'b1;
            $display("tb_top: FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
